// File: design/idxarr_pkg.sv
// idxarr_pkg: shared types and constants for the indexed array block
// holds request modes, status codes, sequencer states and field widths
// no dependencies
package idxarr_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int FILL_W = 7;

  typedef enum logic [2:0] {
    MODE_GET    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_PUSH   = 3'd2,
    MODE_POP    = 3'd3,
    MODE_REMOVE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_SHIFT
  } state_t;

endpackage

// File: design/indexed_array_with_push_pop_remove.sv
// indexed_array_with_push_pop_remove: bounded array with get, set, push, pop and remove
// element store in one synchronous memory (one write port, one read port), fill count in flops
// depends on idxarr_pkg
//
// usage:
//   a request beat is taken at a rising edge where start is high and busy is low;
//   it carries in_mode, in_index and in_write_value.
//   each request gives exactly one result beat: out_strobe is high for one cycle,
//   with out_read_value, out_status and out_fill_count valid in that cycle.
//   the receiver cannot stall; the result is gone after that cycle.
// timing: the result strobe comes in the cycle right after the request is taken.
// throughput: get, set, push, pop and remove of the last element need one memory
//   access each; busy stays low during their result cycle, so one request per cycle.
//   remove with later elements shifts them one per cycle through the memory's
//   read and write ports; busy stays high until the last of them is written.
// reset: synchronous, active low; the array is empty afterwards and no result
//   is pending. the store itself is not cleared: only entries below the count
//   are ever read, and each of them was written by a push.
module indexed_array_with_push_pop_remove
  import idxarr_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [VAL_W-1:0]  in_write_value,
  output logic              out_strobe,
  output logic [VAL_W-1:0]  out_read_value,
  output logic [1:0]        out_status,
  output logic [FILL_W-1:0] out_fill_count
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  status_t                  status_r, status_nxt;
  logic                     rsel_r, rsel_nxt;
  logic                     shift_r, shift_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [ELEMENT_WIDTH-1:0] rdata_r;
  logic [ELEMENT_WIDTH-1:0] store_r [CAPACITY];

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;

  logic                     accept;
  logic                     idx_ok;
  logic [AW-1:0]            idx_a;
  logic [CMP_W-1:0]         idx_ext, cnt_ext;

  assign idx_ext = CMP_W'(in_index);
  assign cnt_ext = CMP_W'(count_r);
  assign idx_ok  = idx_ext < cnt_ext;
  assign idx_a   = AW'(in_index);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rsel_nxt   = rsel_r;
    shift_nxt  = shift_r;
    ptr_nxt    = ptr_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ptr_r;
    mem_wdata  = rdata_r;
    mem_raddr  = AW'(32'(ptr_r) + 32'd1);
    busy       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_RESP: begin
        busy = shift_r;
        if (shift_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(32'(ptr_r) + 32'd1);
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        busy      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = rdata_r;
        if (CNT_W'(ptr_r) + CNT_W'(1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(32'(ptr_r) + 32'd2);
          ptr_nxt   = AW'(32'(ptr_r) + 32'd1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        busy      = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase

    accept = start && !busy;
    if (accept) begin
      state_nxt  = ST_RESP;
      status_nxt = STAT_OK;
      rsel_nxt   = 1'b0;
      shift_nxt  = 1'b0;
      case (in_mode)
        MODE_GET: begin
          if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = idx_a;
            rsel_nxt  = 1'b1;
          end else begin
            status_nxt = STAT_BOUNDS;
          end
        end
        MODE_SET: begin
          if (idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = idx_a;
            mem_wdata = ELEMENT_WIDTH'(in_write_value);
          end else begin
            status_nxt = STAT_BOUNDS;
          end
        end
        MODE_PUSH: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            status_nxt = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_r);
            mem_wdata = ELEMENT_WIDTH'(in_write_value);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_POP: begin
          if (count_r == '0) begin
            status_nxt = STAT_BOUNDS;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_r - CNT_W'(1));
            count_nxt = count_r - CNT_W'(1);
            rsel_nxt  = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = idx_a;
            count_nxt = count_r - CNT_W'(1);
            rsel_nxt  = 1'b1;
            ptr_nxt   = idx_a;
            shift_nxt = (idx_ext + CMP_W'(1)) < cnt_ext;
          end else begin
            status_nxt = STAT_BOUNDS;
          end
        end
        default: begin
          status_nxt = STAT_BOUNDS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rsel_r   <= rsel_nxt;
    shift_r  <= shift_nxt;
    ptr_r    <= ptr_nxt;
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  assign out_strobe     = (state_r == ST_RESP);
  assign out_read_value = rsel_r ? VAL_W'(rdata_r) : '0;
  assign out_status     = status_r;
  assign out_fill_count = FILL_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("no result beat after request");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result beat without request");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status while not full");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry in one cycle");
`endif

endmodule

// File: sim/indexed_array_with_push_pop_remove_tb.sv
// indexed_array_with_push_pop_remove_tb: self-checking bench for the indexed array block
// drives get/set/push/pop/remove/bad-mode beats in random bursts and checks every
// result beat against an in-bench array model; depends on idxarr_pkg and the block
`timescale 1ns / 100ps

module indexed_array_with_push_pop_remove_tb;
  import idxarr_pkg::*;

  localparam int RANDOM_REQUESTS = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 16;

  typedef struct {
    logic [2:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] wval;
    bit               wait_idle;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0]  rval;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_mode = MODE_GET;
  logic [IDX_W-1:0]  in_index = '0;
  logic [VAL_W-1:0]  in_write_value = '0;
  logic              out_strobe;
  logic [VAL_W-1:0]  out_read_value;
  logic [1:0]        out_status;
  logic [FILL_W-1:0] out_fill_count;

  request_t pending_requests[$];
  reply_t   expected_replies[$];

  logic [VAL_W-1:0]  array_image[CAPACITY_DEF];
  logic [FILL_W-1:0] array_fill = '0;

  int plan_fill = 0;
  int mismatches = 0;
  int replies_seen = 0;
  int mode_hits[8];
  int full_hits = 0;
  int bounds_hits = 0;
  int peak_fill = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  indexed_array_with_push_pop_remove u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_index       (in_index),
    .in_write_value (in_write_value),
    .out_strobe     (out_strobe),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  always #1 clk = ~clk;

  // array model: applies one request and queues the reply it must give
  task automatic apply_array_access(input logic [2:0] mode, input logic [IDX_W-1:0] idx,
                                    input logic [VAL_W-1:0] wval);
    reply_t r;
    r.rval   = '0;
    r.status = STAT_OK;
    mode_hits[mode]++;
    case (mode)
      MODE_GET: begin
        if (idx < array_fill) r.rval = array_image[idx];
        else r.status = STAT_BOUNDS;
      end
      MODE_SET: begin
        if (idx < array_fill) array_image[idx] = wval;
        else r.status = STAT_BOUNDS;
      end
      MODE_PUSH: begin
        if (array_fill >= CAPACITY_DEF) begin
          r.status = STAT_FULL;
        end else begin
          array_image[array_fill] = wval;
          array_fill++;
        end
      end
      MODE_POP: begin
        if (array_fill == 0) begin
          r.status = STAT_BOUNDS;
        end else begin
          array_fill--;
          r.rval = array_image[array_fill];
        end
      end
      MODE_REMOVE: begin
        if (idx < array_fill) begin
          r.rval = array_image[idx];
          for (int i = int'(idx); i + 1 < array_fill; i++) array_image[i] = array_image[i + 1];
          array_fill--;
        end else begin
          r.status = STAT_BOUNDS;
        end
      end
      default: r.status = STAT_BOUNDS;
    endcase
    r.fill = array_fill;
    if (r.status == STAT_FULL) full_hits++;
    if (r.status == STAT_BOUNDS) bounds_hits++;
    if (array_fill > peak_fill) peak_fill = int'(array_fill);
    expected_replies.push_back(r);
  endtask

  // plan_fill tracks the fill level so indexes can be aimed inside the array
  task automatic queue_request(input logic [2:0] mode, input logic [IDX_W-1:0] idx,
                               input logic [VAL_W-1:0] wval, input bit wait_idle);
    request_t q;
    q.mode      = mode;
    q.idx       = idx;
    q.wval      = wval;
    q.wait_idle = wait_idle;
    pending_requests.push_back(q);
    case (mode)
      MODE_PUSH:   if (plan_fill < CAPACITY_DEF) plan_fill++;
      MODE_POP:    if (plan_fill > 0) plan_fill--;
      MODE_REMOVE: if (idx < plan_fill) plan_fill--;
      default: ;
    endcase
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (plan_fill > 0 && $urandom_range(9, 0) < 8) return IDX_W'($urandom_range(plan_fill - 1, 0));
    return IDX_W'($urandom_range(CAPACITY_DEF - 1, 0));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_random_op(input bit wait_idle);
    int r;
    r = $urandom_range(99, 0);
    if (r < 20) queue_request(MODE_GET, pick_index(), pick_value(), wait_idle);
    else if (r < 40) queue_request(MODE_SET, pick_index(), pick_value(), wait_idle);
    else if (r < 62) queue_request(MODE_PUSH, pick_index(), pick_value(), wait_idle);
    else if (r < 78) queue_request(MODE_POP, pick_index(), pick_value(), wait_idle);
    else if (r < 95) queue_request(MODE_REMOVE, pick_index(), pick_value(), wait_idle);
    else queue_request(3'($urandom_range(7, int'(MODE_REMOVE) + 1)), pick_index(),
                       pick_value(), wait_idle);
  endtask

  // stimulus plan
  initial begin
    int n_random;
    int seg;
    n_random = 0;

    queue_request(MODE_POP, '0, '0, 1'b0);
    queue_request(MODE_GET, '0, '0, 1'b0);
    queue_request(MODE_REMOVE, '0, '0, 1'b0);
    queue_request(MODE_SET, '1, '1, 1'b0);
    for (int m = int'(MODE_REMOVE) + 1; m < 8; m++) queue_request(3'(m), '1, '1, 1'b0);
    queue_request(MODE_PUSH, '0, '0, 1'b0);
    queue_request(MODE_PUSH, '1, '1, 1'b0);
    queue_request(MODE_PUSH, '0, 32'hA5A5_A5A5, 1'b0);
    queue_request(MODE_PUSH, '0, 32'h5A5A_5A5A, 1'b0);
    queue_request(MODE_GET, '0, '0, 1'b1);
    queue_request(MODE_GET, 6'd3, '0, 1'b0);
    queue_request(MODE_GET, 6'd4, '0, 1'b0);
    queue_request(MODE_GET, '1, '0, 1'b0);
    queue_request(MODE_SET, 6'd1, 32'h1234_5678, 1'b0);
    queue_request(MODE_GET, 6'd1, '0, 1'b0);
    queue_request(MODE_REMOVE, 6'd1, '0, 1'b0);
    queue_request(MODE_GET, 6'd1, '0, 1'b0);
    queue_request(MODE_REMOVE, 6'd2, '0, 1'b0);
    queue_request(MODE_POP, '0, '0, 1'b0);
    queue_request(MODE_POP, '0, '0, 1'b0);
    queue_request(MODE_POP, '0, '0, 1'b0);

    while (n_random < RANDOM_REQUESTS) begin
      seg = $urandom_range(9, 0);
      if (seg < 2) begin
        while (plan_fill < CAPACITY_DEF) begin
          queue_request(MODE_PUSH, pick_index(), pick_value(), 1'b0);
          n_random++;
        end
        repeat ($urandom_range(2, 1)) begin
          queue_request(MODE_PUSH, pick_index(), pick_value(), 1'b0);
          n_random++;
        end
        // remove from the front of a full array: longest shift
        queue_request(MODE_REMOVE, '0, '0, 1'b0);
        n_random++;
      end else if (seg == 2) begin
        while (plan_fill > 0) begin
          queue_request(MODE_POP, pick_index(), pick_value(), 1'b0);
          n_random++;
        end
        queue_request(MODE_POP, pick_index(), pick_value(), 1'b0);
        n_random++;
      end else begin
        repeat ($urandom_range(20, 6)) begin
          queue_random_op(n_random % 97 == 0);
          n_random++;
        end
      end
    end
  end

  // reset
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    request_t q;
    bit       taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) apply_array_access(in_mode, in_index, in_write_value);
      if (!(start && !taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].wait_idle &&
                       (taken || out_strobe || expected_replies.size() != 0))) begin
          q = pending_requests.pop_front();
          in_mode        <= q.mode;
          in_index       <= q.idx;
          in_write_value <= q.wval;
          start          <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_strobe === 1'b1) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: value %h status %0d fill %0d",
                 $time, out_read_value, out_status, out_fill_count);
      end else begin
        e = expected_replies.pop_front();
        if (out_read_value !== e.rval) begin
          mismatches++;
          $display("%0t: read_value expected %h actual %h", $time, e.rval, out_read_value);
        end
        if (out_status !== e.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
        end
        if (out_fill_count !== e.fill) begin
          mismatches++;
          $display("%0t: fill_count expected %0d actual %0d", $time, e.fill, out_fill_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** indexed_array_with_push_pop_remove: FAILED **");
      $finish;
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_replies.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_replies.size());
    end
    $display("covered %0d beats: get %0d, set %0d, push %0d, pop %0d, remove %0d, bad mode %0d",
             replies_seen, mode_hits[MODE_GET], mode_hits[MODE_SET], mode_hits[MODE_PUSH],
             mode_hits[MODE_POP], mode_hits[MODE_REMOVE],
             mode_hits[5] + mode_hits[6] + mode_hits[7]);
    $display("full rejects %0d, out-of-bounds/empty %0d, peak fill %0d, mismatches %0d",
             full_hits, bounds_hits, peak_fill, mismatches);
    if (mismatches == 0) begin
      $display("** indexed_array_with_push_pop_remove: PASSED **");
    end else begin
      $display("** indexed_array_with_push_pop_remove: FAILED **");
    end
    $finish;
  end

endmodule
